// ===== hdl/kar_pkg.sv =====
package kar_pkg;

  localparam int KEY_W         = 6;
  localparam int NOW_W         = 32;
  localparam int COUNT_W       = 32;
  localparam int IVAL_W        = 16;
  localparam int THR_W         = COUNT_W + 1 + IVAL_W;
  localparam int S_TDATA_W     = 40;
  localparam int M_TDATA_W     = 104;
  localparam int KIND_W        = 2;

  localparam int NUM_KEYS_DEF  = 64;
  localparam int TIME_BITS_DEF = 32;

  localparam logic [IVAL_W-1:0] IVAL_RESET = 16'd250;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOWN  = 2'd0,
    KIND_PRESS = 2'd1,
    KIND_UP    = 2'd2
  } kar_kind_t;

  // Control from the decide stage back to the lookup stage.
  typedef struct packed {
    logic             advance;   // decide stage takes the lookup stage's item
    logic             retire;    // item in decide stage finishes this cycle
    logic             busy;      // decide stage holds an item
    logic [KEY_W-1:0] key;       // key of the item in the decide stage
    logic             wr_en;     // write down time and count back to memory
    logic             held_set;
    logic             held_clr;
  } kar_ctl_t;

endpackage

// ===== hdl/kar_ram.sv =====
module kar_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/kar_emit.sv =====
module kar_emit #(
  parameter int TIME_BITS = kar_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s1_valid,
  input  logic [kar_pkg::KEY_W-1:0]       s1_key,
  input  logic                            s1_in_range,
  input  logic                            s1_pressed,
  input  logic                            s1_held,
  input  logic [TIME_BITS-1:0]            s1_now,
  input  logic [TIME_BITS-1:0]            s1_down,
  input  logic [kar_pkg::COUNT_W-1:0]     s1_count,
  input  logic [TIME_BITS-1:0]            s1_elapsed,
  input  logic [kar_pkg::THR_W-1:0]       s1_thr,
  output kar_pkg::kar_ctl_t               ctl,
  output logic [TIME_BITS-1:0]            wr_down,
  output logic [kar_pkg::COUNT_W-1:0]     wr_count,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // event_key[5:0], press_time[37:6], held_duration[69:38], repeats[101:70], zeros
  output logic [kar_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // event_kind[1:0]
  output logic [kar_pkg::KIND_W-1:0]      m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int CW = (TIME_BITS > kar_pkg::THR_W) ? TIME_BITS : kar_pkg::THR_W;

  logic                        s2_valid;
  logic [kar_pkg::KEY_W-1:0]   s2_key;
  logic                        s2_in_range;
  logic                        s2_pressed;
  logic                        s2_held;
  logic [TIME_BITS-1:0]        s2_now;
  logic [TIME_BITS-1:0]        s2_down;
  logic [kar_pkg::COUNT_W-1:0] s2_count;
  logic [TIME_BITS-1:0]        s2_elapsed;
  logic [kar_pkg::THR_W-1:0]   s2_thr;
  logic                        phase;

  logic                        fire;
  logic [1:0]                  nres;
  kar_pkg::kar_kind_t          res_kind;
  logic [TIME_BITS-1:0]        res_ptime;
  logic [TIME_BITS-1:0]        res_dur;
  logic [kar_pkg::COUNT_W-1:0] res_reps;
  logic                        res_last;
  logic                        want_wr;
  logic                        want_set;
  logic                        want_clr;
  logic                        push;
  logic                        retire;
  logic                        advance;

  assign fire = CW'(s2_elapsed) > CW'(s2_thr);

  always_comb begin
    nres      = 2'd0;
    res_kind  = kar_pkg::KIND_DOWN;
    res_ptime = s2_down;
    res_dur   = s2_elapsed;
    res_reps  = s2_count;
    res_last  = 1'b1;
    want_wr   = 1'b0;
    want_set  = 1'b0;
    want_clr  = 1'b0;
    wr_down   = s2_down;
    wr_count  = s2_count;
    if (s2_in_range) begin
      if (s2_pressed) begin
        if (!s2_held) begin
          nres      = 2'd1;
          res_ptime = s2_now;
          res_dur   = '0;
          res_reps  = '0;
          want_wr   = 1'b1;
          want_set  = 1'b1;
          wr_down   = s2_now;
          wr_count  = '0;
        end else if (fire) begin
          nres     = 2'd1;
          res_kind = kar_pkg::KIND_PRESS;
          res_reps = s2_count + 1'b1;
          want_wr  = 1'b1;
          wr_count = s2_count + 1'b1;
        end
      end else if (s2_held) begin
        want_clr = 1'b1;
        // A release with no repeat yet gives one pressed event before the key-up.
        if (s2_count == '0) begin
          nres = 2'd2;
          if (!phase) begin
            res_kind = kar_pkg::KIND_PRESS;
            res_last = 1'b0;
          end else begin
            res_kind = kar_pkg::KIND_UP;
          end
        end else begin
          nres     = 2'd1;
          res_kind = kar_pkg::KIND_UP;
        end
      end
    end
  end

  assign push    = s2_valid && (nres != 2'd0) && (!m_axis_tvalid || m_axis_tready);
  assign retire  = s2_valid && ((nres == 2'd0) || (push && res_last));
  assign advance = !s2_valid || retire;

  always_comb begin
    ctl          = '0;
    ctl.advance  = advance;
    ctl.retire   = retire;
    ctl.busy     = s2_valid;
    ctl.key      = s2_key;
    ctl.wr_en    = retire && want_wr;
    ctl.held_set = retire && want_set;
    ctl.held_clr = retire && want_clr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (advance) begin
        s2_valid <= s1_valid;
      end
      if (retire) begin
        phase <= 1'b0;
      end else if (push) begin
        phase <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_key      <= s1_key;
      s2_in_range <= s1_in_range;
      s2_pressed  <= s1_pressed;
      s2_held     <= s1_held;
      s2_now      <= s1_now;
      s2_down     <= s1_down;
      s2_count    <= s1_count;
      s2_elapsed  <= s1_elapsed;
      s2_thr      <= s1_thr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (push) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      m_axis_tdata <= {2'b00, res_reps, 32'(res_dur), 32'(res_ptime), s2_key};
      m_axis_tuser <= res_kind;
      m_axis_tlast <= res_last;
    end
  end

  a_wr_in_range : assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> s2_valid && s2_in_range && s2_pressed)
    else $error("memory write for an item that does not update the store");

  a_phase_pair : assert property (@(posedge clk) disable iff (rst)
    phase |-> s2_valid && (nres == 2'd2))
    else $error("second result pending for an item with one result");

  a_down_last : assert property (@(posedge clk) disable iff (rst)
    push && (res_kind == kar_pkg::KIND_DOWN) |-> res_last && (res_dur == '0))
    else $error("key-down event not final or with nonzero duration");

  a_no_set_clr : assert property (@(posedge clk) disable iff (rst)
    !(ctl.held_set && ctl.held_clr))
    else $error("held flag set and cleared together");

endmodule

// ===== hdl/key_autorepeat_event_generator.sv =====
// Pipeline: a result is registered through the memory read (with the threshold
// multiply), the decide stage and the output register before it leaves on m_axis.
// Throughput: one input beat per cycle while keys differ and m_axis accepts results;
// a beat for the same key as one in the lookup or decide stage waits until that item
// retires, and a release that yields two results holds the decide stage for both.
// Reset: held flags cleared at once, interval set to 250; the time and count memory
// is not cleared, as a key's entry is used only after its press has written it.
module key_autorepeat_event_generator #(
  parameter int NUM_KEYS  = kar_pkg::NUM_KEYS_DEF,
  parameter int TIME_BITS = kar_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // key_index[5:0], now_ms[37:6], zeros
  input  logic [kar_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // is_pressed[0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // event_key[5:0], press_time[37:6], held_duration[69:38], repeats[101:70], zeros
  output logic [kar_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  // event_kind[1:0]
  output logic [kar_pkg::KIND_W-1:0]        m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kar_pkg::IVAL_W-1:0]        cfg_data
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int WW = TIME_BITS + kar_pkg::COUNT_W;

  logic [kar_pkg::IVAL_W-1:0]  interval;
  logic [NUM_KEYS-1:0]         held_q;

  logic [kar_pkg::KEY_W-1:0]   in_key;
  logic [AW+kar_pkg::KEY_W-1:0] in_key_ext;
  logic [AW-1:0]               in_addr;
  logic                        s_accept;
  logic                        hazard;

  logic                        s1_valid;
  logic [kar_pkg::KEY_W-1:0]   s1_key;
  logic [AW-1:0]               s1_addr;
  logic                        s1_in_range;
  logic                        s1_pressed;
  logic [TIME_BITS-1:0]        s1_now;
  logic                        fwd_hit;
  logic [WW-1:0]               fwd_word;
  logic [WW-1:0]               rd_word;
  logic [WW-1:0]               cur_word;
  logic                        s1_held;
  logic [TIME_BITS-1:0]        s1_down;
  logic [kar_pkg::COUNT_W-1:0] s1_count;
  logic [TIME_BITS-1:0]        s1_elapsed;
  logic [kar_pkg::COUNT_W:0]   s1_count_inc;
  logic [kar_pkg::THR_W-1:0]   s1_thr;

  kar_pkg::kar_ctl_t           ctl;
  logic [AW+kar_pkg::KEY_W-1:0] wr_key_ext;
  logic [AW-1:0]               wr_addr;
  logic [TIME_BITS-1:0]        wr_down;
  logic [kar_pkg::COUNT_W-1:0] wr_count;
  logic [WW-1:0]               wr_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interval <= kar_pkg::IVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      interval <= cfg_data;
    end
  end

  assign in_key     = s_axis_tdata[kar_pkg::KEY_W-1:0];
  assign in_key_ext = {{AW{1'b0}}, in_key};
  assign in_addr    = in_key_ext[AW-1:0];
  assign wr_key_ext = {{AW{1'b0}}, ctl.key};
  assign wr_addr    = wr_key_ext[AW-1:0];
  assign wr_word    = {wr_count, wr_down};

  // A beat for the key now in the lookup stage, or in the decide stage without
  // retiring this cycle, would read a stale memory word.
  assign hazard = (s1_valid && (s1_key == in_key)) ||
                  (ctl.busy && !ctl.retire && (ctl.key == in_key));

  assign s_axis_tready = (!s1_valid || ctl.advance) && !hazard;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (ctl.advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_key      <= in_key;
      s1_addr     <= in_addr;
      s1_in_range <= 32'(in_key) < 32'(NUM_KEYS);
      s1_pressed  <= s_axis_tuser[0];
      s1_now      <= TIME_BITS'(s_axis_tdata[kar_pkg::KEY_W +: kar_pkg::NOW_W]);
      // The retiring item writes this key at the same edge as the memory read.
      fwd_hit     <= ctl.wr_en && (ctl.key == in_key);
      fwd_word    <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_q <= '0;
    end else if (ctl.held_set) begin
      held_q[wr_addr] <= 1'b1;
    end else if (ctl.held_clr) begin
      held_q[wr_addr] <= 1'b0;
    end
  end

  kar_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (wr_addr),
    .wdata (wr_word),
    .re    (s_accept),
    .raddr (in_addr),
    .rdata (rd_word)
  );

  assign cur_word     = fwd_hit ? fwd_word : rd_word;
  assign s1_held      = held_q[s1_addr];
  assign s1_down      = cur_word[TIME_BITS-1:0];
  assign s1_count     = cur_word[WW-1:TIME_BITS];
  assign s1_elapsed   = s1_now - s1_down;
  assign s1_count_inc = {1'b0, s1_count} + 1'b1;
  assign s1_thr       = s1_count_inc * interval;

  kar_emit #(
    .TIME_BITS (TIME_BITS)
  ) u_emit (
    .clk           (clk),
    .rst           (rst),
    .s1_valid      (s1_valid),
    .s1_key        (s1_key),
    .s1_in_range   (s1_in_range),
    .s1_pressed    (s1_pressed),
    .s1_held       (s1_held),
    .s1_now        (s1_now),
    .s1_down       (s1_down),
    .s1_count      (s1_count),
    .s1_elapsed    (s1_elapsed),
    .s1_thr        (s1_thr),
    .ctl           (ctl),
    .wr_down       (wr_down),
    .wr_count      (wr_count),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_no_overrun : assert property (@(posedge clk) disable iff (rst)
    s_accept |-> !s1_valid || ctl.advance)
    else $error("input beat taken while the lookup stage is stalled");

  a_no_same_key : assert property (@(posedge clk) disable iff (rst)
    s_accept && s1_valid |-> s1_key != in_key)
    else $error("same key taken behind itself without write-back");

  a_fwd_only_write : assert property (@(posedge clk) disable iff (rst)
    s_accept && ctl.wr_en && (ctl.key == in_key) |=> fwd_hit)
    else $error("write-back to the key just read not forwarded");

endmodule
